// ----- hw/rtl/u16u8_pkg.sv -----
// Shared types, constants and the code point encoder for the UTF-16/Latin-1 to UTF-8 unit.
package u16u8_pkg;

  localparam int unsigned JobBytes  = 6;
  localparam int unsigned CountW    = 3;
  localparam int unsigned BmpBytes  = 3;

  localparam logic [5:0] SurrHighTag = 6'b110110;
  localparam logic [5:0] SurrLowTag  = 6'b110111;
  localparam logic [10:0] PlaneOffset = 11'h040;

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] ContTag   = 8'h80;

  // Encoded form of one code point of the basic plane: one to three bytes.
  typedef struct packed {
    logic [BmpBytes-1:0][7:0] b;
    logic [1:0]               n;
  } bmp_seq_t;

  // All the bytes that one accepted word gives, in output order from entry 0.
  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic                     eos;
  } job_t;

  function automatic bmp_seq_t enc_bmp(input logic [15:0] cp);
    bmp_seq_t s;
    s = '0;
    if (cp[15:7] == 9'd0) begin
      s.b[0] = cp[7:0];
      s.n    = 2'd1;
    end else if (cp[15:11] == 5'd0) begin
      s.b[0] = LeadTwo | {3'b000, cp[10:6]};
      s.b[1] = ContTag | {2'b00, cp[5:0]};
      s.n    = 2'd2;
    end else begin
      s.b[0] = LeadThree | {4'b0000, cp[15:12]};
      s.b[1] = ContTag | {2'b00, cp[11:6]};
      s.b[2] = ContTag | {2'b00, cp[5:0]};
      s.n    = 2'd3;
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/u16u8_front.sv -----
// Front end: takes input words, pairs surrogates and builds at most one byte job per word.
module u16u8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              mode_i,
  input  logic [15:0]       code_unit_i,
  input  logic              last_unit_i,
  output logic              push_o,
  output u16u8_pkg::job_t   job_o
);

  logic                    held_valid_q, held_valid_d;
  logic [9:0]              held_bits_q, held_bits_d;
  logic                    is_high, is_low, cur_emits;
  logic [15:0]             cur_cp;
  logic [20:0]             pair_cp;
  u16u8_pkg::bmp_seq_t     cur_seq, held_seq;

  always_comb begin
    is_high   = !mode_i && (code_unit_i[15:10] == u16u8_pkg::SurrHighTag);
    is_low    = !mode_i && (code_unit_i[15:10] == u16u8_pkg::SurrLowTag);
    cur_cp    = mode_i ? {8'h00, code_unit_i[7:0]} : code_unit_i;
    cur_seq   = u16u8_pkg::enc_bmp(cur_cp);
    held_seq  = u16u8_pkg::enc_bmp({u16u8_pkg::SurrHighTag, held_bits_q});
    cur_emits = !(is_high && !last_unit_i);
    // The plane offset adds straight onto the high ten bits of the pair.
    pair_cp   = {({1'b0, held_bits_q} + u16u8_pkg::PlaneOffset), code_unit_i[9:0]};

    job_o     = '0;
    job_o.eos = last_unit_i;
    if (held_valid_q && is_low) begin
      job_o.bytes[0] = u16u8_pkg::LeadFour | {5'd0, pair_cp[20:18]};
      job_o.bytes[1] = u16u8_pkg::ContTag | {2'b00, pair_cp[17:12]};
      job_o.bytes[2] = u16u8_pkg::ContTag | {2'b00, pair_cp[11:6]};
      job_o.bytes[3] = u16u8_pkg::ContTag | {2'b00, pair_cp[5:0]};
      job_o.count    = 3'd4;
    end else if (held_valid_q) begin
      // Unpaired surrogate goes out first, then whatever this word gives.
      job_o.bytes[0] = held_seq.b[0];
      job_o.bytes[1] = held_seq.b[1];
      job_o.bytes[2] = held_seq.b[2];
      if (cur_emits) begin
        job_o.bytes[3] = cur_seq.b[0];
        job_o.bytes[4] = cur_seq.b[1];
        job_o.bytes[5] = cur_seq.b[2];
        job_o.count    = 3'd3 + {1'b0, cur_seq.n};
      end else begin
        job_o.count    = 3'd3;
      end
    end else if (cur_emits) begin
      job_o.bytes[0] = cur_seq.b[0];
      job_o.bytes[1] = cur_seq.b[1];
      job_o.bytes[2] = cur_seq.b[2];
      job_o.count    = {1'b0, cur_seq.n};
    end

    push_o = accept_i && (job_o.count != 3'd0);

    held_valid_d = held_valid_q;
    held_bits_d  = held_bits_q;
    if (accept_i) begin
      held_valid_d = is_high && !last_unit_i && !(held_valid_q && is_low);
      held_bits_d  = held_valid_d ? code_unit_i[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_bits_q  <= 10'd0;
    end else begin
      held_valid_q <= held_valid_d;
      held_bits_q  <= held_bits_d;
    end
  end

endmodule

// ----- hw/rtl/u16u8_queue.sv -----
// Short job queue between the front end and the byte serialiser.
module u16u8_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u16u8_pkg::job_t   push_job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output u16u8_pkg::job_t   head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u16u8_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  always_comb begin
    full_o       = (cnt_q == CntW'(Depth));
    head_valid_o = (cnt_q != '0);
    head_job_o   = mem_q[rd_ptr_q];
    do_push      = push_i && !full_o;
    do_pop       = pop_i && head_valid_o;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- hw/rtl/u16u8_back.sv -----
// Back end: sends the head job's bytes through an output register, one per cycle unless the output stalls.
module u16u8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  u16u8_pkg::job_t   head_job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic              out_eos_o
);

  logic                          valid_q, valid_d;
  logic [7:0]                    byte_q;
  logic                          last_q, eos_q;
  logic [u16u8_pkg::CountW-1:0]  idx_q, idx_d;
  logic                          load, fin;

  always_comb begin
    load    = head_valid_i && (!valid_q || out_ready_i);
    fin     = (idx_q == head_job_i.count - 1'b1);
    pop_o   = load && fin;
    idx_d   = idx_q;
    if (load) begin
      idx_d = fin ? '0 : idx_q + 1'b1;
    end
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_job_i.bytes[idx_q];
      last_q <= fin;
      eos_q  <= fin && head_job_i.eos;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_eos_o   = eos_q;

endmodule

// ----- hw/rtl/utf16_latin1_to_utf8_transcoder_unit.sv -----
// Top level of the UTF-16LE / Latin-1 to UTF-8 transcoder.
//
// Each input word carries one UTF-16LE code unit (tuser = 0) or one Latin-1 byte in the
// low eight bits of tdata (tuser = 1), with tlast marking the final unit of a string.
// The unit sends the UTF-8 bytes for each word, one byte per output word and one per
// cycle at most; output tlast marks the final byte caused by an input word and output
// tuser marks the final byte of a whole string. A high surrogate that is not the final
// unit is held back and produces nothing on its own; if the next word is a low surrogate
// the pair goes out as one four-byte sequence, otherwise the held surrogate is sent as
// three bytes followed by the bytes of the new word. Lone low surrogates and a high
// surrogate in the final position are sent as three bytes each. A word therefore causes
// from none up to six output bytes, typically one to three. The front end classifies
// and encodes a word in the cycle it is accepted and parks the result in a queue of
// QueueDepth entries, so a new word is taken while earlier bytes are still going out,
// and input stalls only when that queue is full. The first byte of an accepted word
// passes through its queue entry and then the back end's output register before it
// appears on the output.
module utf16_latin1_to_utf8_transcoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tuser_i,   // [0] mode: 0 UTF-16LE, 1 Latin-1
  input  logic        s_axis_tlast_i,   // last_unit
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tuser_o,   // [0] end_of_string
  output logic        m_axis_tlast_o    // last_of_run
);

  logic              accept;
  logic              push;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  u16u8_pkg::job_t   new_job;
  u16u8_pkg::job_t   head_job;

  // The front end never waits on the back end directly: only a full queue stalls input.
  assign s_axis_tready_o = !queue_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (s_axis_tuser_i),
    .code_unit_i (s_axis_tdata_i),
    .last_unit_i (s_axis_tlast_i),
    .push_o      (push),
    .job_o       (new_job)
  );

  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (new_job),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_eos_o    (m_axis_tuser_o)
  );

endmodule
